/* design/bpq_pkg.sv */
// Shared types and constants of the bounded priority queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package bpq_pkg;

	// Storage geometry.
	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Field widths.
	localparam int VALUE_W = 32;
	localparam int PRIO_W  = 16;
	localparam int ENTRY_W = VALUE_W + PRIO_W;

	// Request kinds.
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    write_tail;
		logic    start_scan;
		logic    scan;
		logic    start_shift;
		logic    shift;
		logic    finish;
		status_t code;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_remove;
		logic full;
		logic empty;
		logic walk_done;
		logic out_free;
	} dp_sts_t;

endpackage

/* design/bounded_priority_queue_unit.sv */
// Top level of the bounded priority queue; ties the controller to the datapath.
// Depends on bpq_pkg, bpq_ctrl and bpq_datapath.
//
// Holds up to 16 value/priority pairs in arrival order in a single RAM. The
// result is presented in the same cycle that the next request can be taken.
// The single RAM read port is walked once over all N entries, N being the
// entry count, to find the highest priority (earliest wins on ties), then over
// the entries behind the winner to move each down one place. One request is in
// flight at a time; a new request is taken once the previous result has been
// written to the output register, even while that result still waits to be
// taken.
module bounded_priority_queue_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                kind,
	input  logic signed [bpq_pkg::VALUE_W-1:0]  item_value,
	input  logic signed [bpq_pkg::PRIO_W-1:0]   item_priority,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [bpq_pkg::VALUE_W-1:0]  removed_value,
	output logic [1:0]                          status,
	output logic [bpq_pkg::CNT_W-1:0]           occupancy
);

	bpq_pkg::dp_cmd_t cmd;
	bpq_pkg::dp_sts_t sts;

	bpq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	bpq_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.kind         (kind),
		.item_value   (item_value),
		.item_priority(item_priority),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.removed_value(removed_value),
		.status       (status),
		.occupancy    (occupancy)
	);

endmodule

/* design/bpq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
module bpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/bpq_datapath.sv */
// Datapath of the bounded priority queue: entry RAM, count, scan/shift walker,
// best-entry tracking and the result register. Depends on bpq_pkg and bpq_ram.
module bpq_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                kind,
	input  logic signed [bpq_pkg::VALUE_W-1:0]  item_value,
	input  logic signed [bpq_pkg::PRIO_W-1:0]   item_priority,
	input  bpq_pkg::dp_cmd_t                    cmd,
	output bpq_pkg::dp_sts_t                    sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [bpq_pkg::VALUE_W-1:0]  removed_value,
	output logic [1:0]                          status,
	output logic [bpq_pkg::CNT_W-1:0]           occupancy
);

	// Latched request.
	logic                                kind_q;
	logic signed [bpq_pkg::VALUE_W-1:0]  val_q;
	logic signed [bpq_pkg::PRIO_W-1:0]   prio_q;

	// Occupancy and walker.
	logic [bpq_pkg::CNT_W-1:0] count_q;
	logic [bpq_pkg::CNT_W-1:0] count_next;
	logic [bpq_pkg::CNT_W-1:0] ptr_q;
	logic                      pend_q;
	logic [bpq_pkg::IDX_W-1:0] pend_idx_s1;
	logic                      rd_issue;

	// Best entry found by the scan.
	logic [bpq_pkg::IDX_W-1:0]          best_idx_q;
	logic signed [bpq_pkg::PRIO_W-1:0]  best_prio_q;
	logic signed [bpq_pkg::VALUE_W-1:0] best_val_q;
	logic                               take_best;

	// Result register.
	logic                               out_valid_q;
	logic signed [bpq_pkg::VALUE_W-1:0] out_value_q;
	bpq_pkg::status_t                   out_status_q;
	logic [bpq_pkg::CNT_W-1:0]          out_count_q;

	// RAM ports.
	logic                               ram_we;
	logic [bpq_pkg::IDX_W-1:0]          ram_waddr;
	logic [bpq_pkg::ENTRY_W-1:0]        ram_wdata;
	logic [bpq_pkg::ENTRY_W-1:0]        ram_rdata;
	logic signed [bpq_pkg::PRIO_W-1:0]  rd_prio;
	logic signed [bpq_pkg::VALUE_W-1:0] rd_val;

	bpq_ram #(
		.WIDTH(bpq_pkg::ENTRY_W),
		.DEPTH(bpq_pkg::QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ptr_q[bpq_pkg::IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	assign rd_prio = ram_rdata[bpq_pkg::ENTRY_W-1 -: bpq_pkg::PRIO_W];
	assign rd_val  = ram_rdata[bpq_pkg::VALUE_W-1:0];

	// The walker reads one entry per cycle while the pointer is below the count.
	assign rd_issue = (cmd.scan || cmd.shift) && (ptr_q < count_q);

	// An entry wins if it is the first one or has a strictly higher priority.
	assign take_best = cmd.scan && pend_q &&
		((pend_idx_s1 == '0) || (rd_prio > best_prio_q));

	// Writes come from an insert at the tail or from the shift moving an entry down.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[bpq_pkg::IDX_W-1:0];
		ram_wdata = {prio_q, val_q};
		if (cmd.write_tail) begin
			ram_we = 1'b1;
		end else if (cmd.shift && pend_q) begin
			ram_we    = 1'b1;
			ram_waddr = pend_idx_s1 - bpq_pkg::IDX_W'(1);
			ram_wdata = ram_rdata;
		end
	end

	// Count after the current command.
	always_comb begin
		count_next = count_q;
		if (cmd.write_tail) begin
			count_next = count_q + bpq_pkg::CNT_W'(1);
		end else if (cmd.finish && (cmd.code == bpq_pkg::ST_OK) &&
				(kind_q == bpq_pkg::KIND_REMOVE)) begin
			count_next = count_q - bpq_pkg::CNT_W'(1);
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ptr_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			pend_q  <= rd_issue;
			if (cmd.start_scan) begin
				ptr_q <= '0;
			end else if (cmd.start_shift) begin
				ptr_q <= bpq_pkg::CNT_W'(best_idx_q) + bpq_pkg::CNT_W'(1);
			end else if (rd_issue) begin
				ptr_q <= ptr_q + bpq_pkg::CNT_W'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			val_q  <= item_value;
			prio_q <= item_priority;
		end
		pend_idx_s1 <= ptr_q[bpq_pkg::IDX_W-1:0];
		if (take_best) begin
			best_idx_q  <= pend_idx_s1;
			best_prio_q <= rd_prio;
			best_val_q  <= rd_val;
		end
		if (cmd.finish) begin
			out_status_q <= cmd.code;
			out_count_q  <= count_next;
			if ((cmd.code == bpq_pkg::ST_OK) && (kind_q == bpq_pkg::KIND_REMOVE)) begin
				out_value_q <= best_val_q;
			end else begin
				out_value_q <= '0;
			end
		end
	end

	// Status toward the controller.
	assign sts.is_remove = (kind_q == bpq_pkg::KIND_REMOVE);
	assign sts.full      = (count_q == bpq_pkg::CNT_W'(bpq_pkg::QUEUE_DEPTH));
	assign sts.empty     = (count_q == '0);
	assign sts.walk_done = (ptr_q == count_q) && !pend_q;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign removed_value = out_value_q;
	assign status        = out_status_q;
	assign occupancy     = out_count_q;

	// The count never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bpq_pkg::CNT_W'(bpq_pkg::QUEUE_DEPTH))
		else $error("entry count above capacity");

	// A shift write moves an occupied entry one place down, never from slot zero.
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift && pend_q) |->
		((pend_idx_s1 != '0) && (bpq_pkg::CNT_W'(pend_idx_s1) < count_q)))
		else $error("shift write outside occupied range");

	// A finished request is presented in the next cycle.
	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished result not presented");

endmodule

/* design/bpq_ctrl.sv */
// Controller state machine of the bounded priority queue.
// Sequences insert, scan, shift and result commands; depends on bpq_pkg.
module bpq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  bpq_pkg::dp_sts_t sts,
	output bpq_pkg::dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_SHIFT,
		S_FINISH
	} state_t;

	state_t           state_q;
	bpq_pkg::status_t code_q;

	// State and result code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= bpq_pkg::ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (!sts.is_remove) begin
						code_q  <= sts.full ? bpq_pkg::ST_OVERFLOW : bpq_pkg::ST_OK;
						state_q <= S_FINISH;
					end else if (sts.empty) begin
						code_q  <= bpq_pkg::ST_UNDERFLOW;
						state_q <= S_FINISH;
					end else begin
						code_q  <= bpq_pkg::ST_OK;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (sts.walk_done) begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (sts.walk_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command decode.
	always_comb begin
		cmd      = '0;
		cmd.code = code_q;
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_DECIDE: begin
				cmd.write_tail = !sts.is_remove && !sts.full;
				cmd.start_scan = sts.is_remove && !sts.empty;
			end
			S_SCAN: begin
				cmd.scan        = 1'b1;
				cmd.start_shift = sts.walk_done;
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
			end
			S_FINISH: begin
				cmd.finish = sts.out_free;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

	// A result is only written when the output register can take it.
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("result written over a pending result");

	// A loaded request is always decided in the next cycle.
	a_load_decide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_DECIDE))
		else $error("loaded request not decided");

	// An insert never writes into a full store.
	a_no_full_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_tail |-> !sts.full)
		else $error("insert into full store");

endmodule
